FILE: hw/rtl/ktsd_pkg.sv
// ktsd_pkg: beat types, register indexes and fixed widths for the state derivative core
// no dependencies; imported by ktsd_divider and kepler_thrust_state_derivative_core
`default_nettype none

package ktsd_pkg;

    localparam int WORD_W     = 32;              // Q16.16 word
    localparam int MU_W       = 31;              // unsigned mu
    localparam int SQRT_STEPS = 32;              // one result bit per step
    localparam int PROD_W     = MU_W + WORD_W;   // mu * |p|
    localparam int DEN_W      = 3 * WORD_W;      // r^3
    localparam int Q_W        = 41;              // quotient bits kept
    localparam int ACC_W      = 43;              // thrust +/- gravity before clamp
    localparam int DIV_STAGES = Q_W + 1;         // range check plus one bit per stage

    localparam logic [Q_W-1:0] GRAV_CAP = Q_W'(1) << (Q_W - 1);

    // configuration register indexes
    localparam logic [1:0] REG_GRAV_PARAM = 2'd0;
    localparam logic [1:0] REG_THRUST_X   = 2'd1;
    localparam logic [1:0] REG_THRUST_Y   = 2'd2;
    localparam logic [1:0] REG_THRUST_Z   = 2'd3;

    typedef struct packed {
        logic signed [WORD_W-1:0] pos_x;
        logic signed [WORD_W-1:0] pos_y;
        logic signed [WORD_W-1:0] pos_z;
        logic signed [WORD_W-1:0] vel_x;
        logic signed [WORD_W-1:0] vel_y;
        logic signed [WORD_W-1:0] vel_z;
    } state_t;

    typedef struct packed {
        logic signed [WORD_W-1:0] dpos_x;
        logic signed [WORD_W-1:0] dpos_y;
        logic signed [WORD_W-1:0] dpos_z;
        logic signed [WORD_W-1:0] dvel_x;
        logic signed [WORD_W-1:0] dvel_y;
        logic signed [WORD_W-1:0] dvel_z;
        logic                     singular;
        logic                     overflow;
    } deriv_t;

    // per-beat sideband carried alongside the arithmetic
    typedef struct packed {
        logic [2:0][WORD_W-1:0] vel;
        logic [2:0]             neg;
        logic                   sing;
    } side_t;

endpackage

`default_nettype wire

FILE: hw/rtl/ktsd_divider.sv
// ktsd_divider: pipelined restoring divider, floor(prod * 2^32 / den) capped at 2^40
// one quotient bit per stage; uses ktsd_pkg
`default_nettype none

module ktsd_divider (
    input  wire logic                        clk,
    input  wire logic                        en,
    input  wire logic [ktsd_pkg::PROD_W-1:0] prod,
    input  wire logic [ktsd_pkg::DEN_W-1:0]  den,
    output logic      [ktsd_pkg::Q_W-1:0]    quot
);
    import ktsd_pkg::*;

    localparam int NUM_W = PROD_W + 32;

    logic [DEN_W-1:0]  rem_reg  [0:DIV_STAGES-1];
    logic [Q_W-1:0]    q_reg    [0:DIV_STAGES-1];
    logic              cap_reg  [0:DIV_STAGES-1];
    logic [PROD_W-1:0] prod_reg [0:DIV_STAGES-1];
    logic [DEN_W-1:0]  den_reg  [0:DIV_STAGES-1];

    logic [NUM_W-Q_W-1:0] num_top;

    // top part of the numerator; quotient >= 2^41 if it already reaches den
    assign num_top = prod[PROD_W-1:Q_W-32];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            cap_reg[0]  <= {{(DEN_W-(NUM_W-Q_W)){1'b0}}, num_top} >= den;
            rem_reg[0]  <= {{(DEN_W-(NUM_W-Q_W)){1'b0}}, num_top};
            q_reg[0]    <= '0;
            prod_reg[0] <= prod;
            den_reg[0]  <= den;
        end
    end

    for (genvar j = 0; j < Q_W; j++)
    begin : g_step
        localparam int B = Q_W - 1 - j;
        logic           nbit;
        logic [DEN_W:0] shifted;
        logic           ge;

        if (B >= 32)
        begin : g_bit
            assign nbit = prod_reg[j][B-32];
        end
        else
        begin : g_zero
            assign nbit = 1'b0;
        end

        assign shifted = {rem_reg[j], nbit};
        assign ge      = shifted >= {1'b0, den_reg[j]};

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[j+1]  <= ge ? DEN_W'(shifted - {1'b0, den_reg[j]}) : DEN_W'(shifted);
                q_reg[j+1]    <= {q_reg[j][Q_W-2:0], ge};
                cap_reg[j+1]  <= cap_reg[j];
                prod_reg[j+1] <= prod_reg[j];
                den_reg[j+1]  <= den_reg[j];
            end
        end
    end

    assign quot = (cap_reg[DIV_STAGES-1] || q_reg[DIV_STAGES-1] > GRAV_CAP)
                  ? GRAV_CAP : q_reg[DIV_STAGES-1];

endmodule

`default_nettype wire

FILE: hw/rtl/kepler_thrust_state_derivative_core.sv
// kepler_thrust_state_derivative_core: two-body gravity plus constant thrust, Q16.16
// depends on ktsd_pkg and ktsd_divider
//
//  channel   | signals                          | beat
//  ----------+----------------------------------+-------------------------------
//  state     | state_valid, state_ready, state  | position and velocity in
//  deriv     | deriv_valid, deriv_ready, deriv  | derivative, singular, overflow
//  cfg       | cfg_we, cfg_addr, cfg_data       | mu and thrust registers
//
// one beat enters per cycle while the pipe advances; its depth is set by the
// 32-step square root and the 42-stage divider
// every stage moves together; the whole pipe holds while the output beat waits
// a bubble in the output register lets a new beat in even when deriv_ready is low
// reset clears the valid bits, mu to 1.0 and thrust to zero
`default_nettype none

module kepler_thrust_state_derivative_core (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             state_valid,
    output logic                  state_ready,
    input  wire ktsd_pkg::state_t state,
    output logic                  deriv_valid,
    input  wire logic             deriv_ready,
    output ktsd_pkg::deriv_t      deriv,
    input  wire logic             cfg_we,
    input  wire logic [1:0]       cfg_addr,
    input  wire logic [31:0]      cfg_data
);
    import ktsd_pkg::*;

    // stage map: abs, squares, sum, sqrt steps, r^2 and mu*|p|, partials, r^3,
    // divider stages, output
    localparam int ST_SQRT0 = 2;
    localparam int ST_MUL   = ST_SQRT0 + SQRT_STEPS + 1;
    localparam int ST_DEN   = ST_MUL + 2;
    localparam int ST_LAST  = ST_DEN + DIV_STAGES;
    localparam int NSTAGE   = ST_LAST + 2;

    // configuration registers
    logic [MU_W-1:0]          mu_reg;
    logic signed [WORD_W-1:0] thr_reg [0:2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mu_reg     <= MU_W'(65536);
            thr_reg[0] <= '0;
            thr_reg[1] <= '0;
            thr_reg[2] <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_addr)
                REG_GRAV_PARAM: mu_reg     <= cfg_data[MU_W-1:0];
                REG_THRUST_X:   thr_reg[0] <= cfg_data;
                REG_THRUST_Y:   thr_reg[1] <= cfg_data;
                REG_THRUST_Z:   thr_reg[2] <= cfg_data;
                default:        mu_reg     <= mu_reg;
            endcase
        end
    end

    // pipe advance: everything moves unless the output beat is stuck
    logic              adv;
    logic [NSTAGE-1:0] vld_reg;

    assign adv         = !vld_reg[NSTAGE-1] || deriv_ready;
    assign state_ready = adv;
    assign deriv_valid = vld_reg[NSTAGE-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (adv)
            vld_reg <= {vld_reg[NSTAGE-2:0], state_valid};
    end

    logic [2:0][WORD_W-1:0] pos_in;
    assign pos_in = {state.pos_z, state.pos_y, state.pos_x};

    // magnitudes travel until mu * |p|
    logic [WORD_W-1:0] mag_reg [0:ST_MUL-1][0:2];

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int i = 0; i < 3; i++)
            begin
                mag_reg[0][i] <= pos_in[i][WORD_W-1] ? WORD_W'(-pos_in[i]) : pos_in[i];
                for (int t = 1; t < ST_MUL; t++)
                    mag_reg[t][i] <= mag_reg[t-1][i];
            end
        end
    end

    // squares, then their sum (three squares of at most 2^62 fit 64 bits)
    logic [2*WORD_W-1:0] sq_reg [0:2];
    logic [2*WORD_W-1:0] sqs_reg [0:SQRT_STEPS];
    logic [2*WORD_W-1:0] sqr_reg [0:SQRT_STEPS];

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int i = 0; i < 3; i++)
                sq_reg[i] <= mag_reg[0][i] * mag_reg[0][i];
            sqs_reg[0] <= sq_reg[0] + sq_reg[1] + sq_reg[2];
            sqr_reg[0] <= '0;
        end
    end

    // integer square root, one result bit per stage
    for (genvar k = 0; k < SQRT_STEPS; k++)
    begin : g_sqrt
        localparam logic [2*WORD_W-1:0] BIT = (2*WORD_W)'(1) << (2*WORD_W - 2 - 2*k);
        logic [2*WORD_W-1:0] trial;

        assign trial = sqr_reg[k] + BIT;

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                if (sqs_reg[k] >= trial)
                begin
                    sqs_reg[k+1] <= sqs_reg[k] - trial;
                    sqr_reg[k+1] <= (sqr_reg[k] >> 1) + BIT;
                end
                else
                begin
                    sqs_reg[k+1] <= sqs_reg[k];
                    sqr_reg[k+1] <= sqr_reg[k] >> 1;
                end
            end
        end
    end

    // sideband line, sing decided once the radius is known
    side_t side_reg [0:ST_LAST];

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            side_reg[0].vel  <= {state.vel_z, state.vel_y, state.vel_x};
            side_reg[0].neg  <= {pos_in[2][WORD_W-1], pos_in[1][WORD_W-1],
                                 pos_in[0][WORD_W-1]};
            side_reg[0].sing <= 1'b0;
            for (int t = 1; t <= ST_LAST; t++)
            begin
                if (t != ST_MUL)
                    side_reg[t] <= side_reg[t-1];
            end
            side_reg[ST_MUL].vel  <= side_reg[ST_MUL-1].vel;
            side_reg[ST_MUL].neg  <= side_reg[ST_MUL-1].neg;
            side_reg[ST_MUL].sing <= (sqr_reg[SQRT_STEPS][WORD_W-1:0] == '0);
        end
    end

    // r^2 and mu * |p|, then the two halves of r^3, then r^3
    logic [WORD_W-1:0]   rad;
    logic [WORD_W-1:0]   rad_reg;
    logic [2*WORD_W-1:0] rr_reg;
    logic [2*WORD_W-1:0] plo_reg;
    logic [2*WORD_W-1:0] phi_reg;
    logic [DEN_W-1:0]    den_reg;
    logic [PROD_W-1:0]   prod_reg [0:2][0:2];

    assign rad = sqr_reg[SQRT_STEPS][WORD_W-1:0];

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            rr_reg     <= rad * rad;
            rad_reg    <= rad;
            plo_reg    <= rr_reg[WORD_W-1:0] * rad_reg;
            phi_reg    <= rr_reg[2*WORD_W-1:WORD_W] * rad_reg;
            den_reg    <= {phi_reg, {WORD_W{1'b0}}} + {{WORD_W{1'b0}}, plo_reg};
            for (int i = 0; i < 3; i++)
            begin
                prod_reg[0][i] <= mu_reg * mag_reg[ST_MUL-1][i];
                prod_reg[1][i] <= prod_reg[0][i];
                prod_reg[2][i] <= prod_reg[1][i];
            end
        end
    end

    // one divider per axis, sharing r^3
    logic [Q_W-1:0] grav [0:2];

    for (genvar a = 0; a < 3; a++)
    begin : g_axis
        ktsd_divider u_div (
            .clk  (clk),
            .en   (adv),
            .prod (prod_reg[2][a]),
            .den  (den_reg),
            .quot (grav[a])
        );
    end

    // thrust plus signed gravity, clamped to the word
    localparam logic signed [ACC_W-1:0] ACC_MAX = ACC_W'((64'sd1 <<< (WORD_W - 1)) - 1);
    localparam logic signed [ACC_W-1:0] ACC_MIN = -ACC_MAX - ACC_W'(1);

    logic signed [ACC_W-1:0]  acc [0:2];
    logic signed [WORD_W-1:0] dvel [0:2];
    logic [2:0]               sat;
    side_t                    sd;
    deriv_t                   deriv_next;
    deriv_t                   deriv_reg;

    assign sd = side_reg[ST_LAST];

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            acc[i] = ACC_W'(thr_reg[i]);
            if (!sd.sing)
            begin
                if (sd.neg[i])
                    acc[i] = acc[i] + $signed({2'b00, grav[i]});
                else
                    acc[i] = acc[i] - $signed({2'b00, grav[i]});
            end
            sat[i]  = 1'b1;
            dvel[i] = WORD_W'(acc[i]);
            if (acc[i] > ACC_MAX)
                dvel[i] = WORD_W'(ACC_MAX);
            else if (acc[i] < ACC_MIN)
                dvel[i] = WORD_W'(ACC_MIN);
            else
                sat[i] = 1'b0;
        end
        deriv_next.dpos_x   = sd.vel[0];
        deriv_next.dpos_y   = sd.vel[1];
        deriv_next.dpos_z   = sd.vel[2];
        deriv_next.dvel_x   = dvel[0];
        deriv_next.dvel_y   = dvel[1];
        deriv_next.dvel_z   = dvel[2];
        deriv_next.singular = sd.sing;
        deriv_next.overflow = |sat;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
            deriv_reg <= deriv_next;
    end

    assign deriv = deriv_reg;

`ifndef SYNTHESIS
    // a dropped gravity term leaves bare thrust, which always fits
    a_sing_no_ovf: assert property (@(posedge clk) disable iff (!rst_n)
        deriv_valid && deriv.singular |-> !deriv.overflow)
        else $error("singular beat flagged overflow");

    // an overflow beat carries at least one clamped component
    a_ovf_clamped: assert property (@(posedge clk) disable iff (!rst_n)
        deriv_valid && deriv.overflow |->
            deriv.dvel_x == WORD_W'(ACC_MAX) || deriv.dvel_x == WORD_W'(ACC_MIN) ||
            deriv.dvel_y == WORD_W'(ACC_MAX) || deriv.dvel_y == WORD_W'(ACC_MIN) ||
            deriv.dvel_z == WORD_W'(ACC_MAX) || deriv.dvel_z == WORD_W'(ACC_MIN))
        else $error("overflow without a clamped component");

    // a held pipe keeps every beat where it is
    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !adv |=> $stable(vld_reg))
        else $error("pipe moved while stalled");
`endif

endmodule

`default_nettype wire

FILE: sim/kepler_thrust_state_derivative_core_test.sv
// kepler_thrust_state_derivative_core_test: self-checking bench for the two-body state derivative core
// depends on ktsd_pkg and kepler_thrust_state_derivative_core
`timescale 1ns / 1ps

module kepler_thrust_state_derivative_core_test;
    import ktsd_pkg::*;

    localparam int PIPE_DEPTH  = 81;      // stage depth of the core's pipe
    localparam int STALL_LIMIT = 20000;   // cycles with no beat on either side

    logic        clk;
    logic        rst_n;
    logic        state_valid;
    logic        state_ready;
    state_t      state;
    logic        deriv_valid;
    logic        deriv_ready;
    deriv_t      deriv;
    logic        cfg_we;
    logic [1:0]  cfg_addr;
    logic [31:0] cfg_data;

    kepler_thrust_state_derivative_core DUT (
        .clk         (clk),
        .rst_n       (rst_n),
        .state_valid (state_valid),
        .state_ready (state_ready),
        .state       (state),
        .deriv_valid (deriv_valid),
        .deriv_ready (deriv_ready),
        .deriv       (deriv),
        .cfg_we      (cfg_we),
        .cfg_addr    (cfg_addr),
        .cfg_data    (cfg_data)
    );

    // shadow copy of the registers held by the core
    logic [30:0]        mu_shadow;
    logic signed [31:0] thrust_shadow [3];

    deriv_t  pending_derivs [$];
    int      mismatch_count;
    int      states_sent;
    int      derivs_seen;
    int      singular_seen;
    int      overflow_seen;
    int      quiet_cycles;
    bit      idle_bursts_on;     // random gaps on both sides
    int      hold_off_cycles;    // long receiver stall requested by a test

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // exact integer square root, floor
    function automatic logic [63:0] isqrt(input logic [63:0] s);
        logic [63:0] root;
        logic [63:0] rem;
        logic [63:0] bit_v;
        root  = '0;
        rem   = s;
        bit_v = 64'd1 << 62;
        while (bit_v > rem)
            bit_v = bit_v >> 2;
        while (bit_v != 0)
        begin
            if (rem >= root + bit_v)
            begin
                rem  = rem - (root + bit_v);
                root = (root >> 1) + bit_v;
            end
            else
                root = root >> 1;
            bit_v = bit_v >> 2;
        end
        return root;
    endfunction

    // gravity plus thrust per axis, clamped to the word, as the core computes it
    function automatic deriv_t derive_state(input state_t st);
        deriv_t             d;
        logic signed [63:0] p [3];
        logic [63:0]        mag [3];
        logic [63:0]        sum_sq;
        logic [63:0]        radius;
        logic [127:0]       r_cubed;
        logic [127:0]       numer;
        logic [127:0]       grav;
        logic signed [63:0] acc;
        logic signed [31:0] res [3];
        logic               ovf;
        p[0] = st.pos_x;
        p[1] = st.pos_y;
        p[2] = st.pos_z;
        sum_sq = '0;
        for (int i = 0; i < 3; i++)
        begin
            mag[i] = (p[i] < 0) ? 64'(-p[i]) : 64'(p[i]);
            sum_sq = sum_sq + mag[i] * mag[i];
        end
        radius  = isqrt(sum_sq);
        r_cubed = 128'(radius) * 128'(radius) * 128'(radius);
        ovf     = 1'b0;
        for (int i = 0; i < 3; i++)
        begin
            acc = thrust_shadow[i];
            if (radius != 0 && mag[i] != 0)
            begin
                numer = (128'(mu_shadow) * 128'(mag[i])) << 32;
                grav  = numer / r_cubed;
                if (grav > (128'd1 << 40))
                    grav = 128'd1 << 40;
                if (p[i] > 0)
                    acc = acc - $signed(64'(grav));
                else
                    acc = acc + $signed(64'(grav));
            end
            if (acc > 64'sd2147483647)
            begin
                acc = 64'sd2147483647;
                ovf = 1'b1;
            end
            if (acc < -64'sd2147483648)
            begin
                acc = -64'sd2147483648;
                ovf = 1'b1;
            end
            res[i] = acc[31:0];
        end
        d.dpos_x   = st.vel_x;
        d.dpos_y   = st.vel_y;
        d.dpos_z   = st.vel_z;
        d.dvel_x   = res[0];
        d.dvel_y   = res[1];
        d.dvel_z   = res[2];
        d.singular = (radius == 0);
        d.overflow = ovf;
        return d;
    endfunction

    task automatic report_mismatch(input string field, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("mismatch on beat %0d field %s: got %h, want %h",
                 derivs_seen, field, got, want);
        mismatch_count++;
    endtask

    // register write, only while the core holds nothing
    task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
        @(negedge clk);
        cfg_we   <= 1'b1;
        cfg_addr <= idx;
        cfg_data <= val;
        @(negedge clk);
        cfg_we   <= 1'b0;
        if (idx == REG_GRAV_PARAM)
            mu_shadow = val[30:0];
        else
            thrust_shadow[idx - 1] = val;
    endtask

    task automatic set_regs(input logic [31:0] mu, input logic [31:0] tx,
                            input logic [31:0] ty, input logic [31:0] tz);
        write_reg(REG_GRAV_PARAM, mu);
        write_reg(REG_THRUST_X, tx);
        write_reg(REG_THRUST_Y, ty);
        write_reg(REG_THRUST_Z, tz);
    endtask

    // one state beat: with bursts on, sometimes a random gap first, then hold valid until taken
    task automatic send_state(input state_t st);
        if (idle_bursts_on && $urandom_range(3) == 0)
        begin
            state_valid <= 1'b0;
            repeat ($urandom_range(9, 1)) @(negedge clk);
        end
        state_valid <= 1'b1;
        state       <= st;
        @(posedge clk);
        while (!state_ready)
            @(posedge clk);
        pending_derivs.push_back(derive_state(st));
        states_sent++;
        @(negedge clk);
    endtask

    task automatic drain_pipe();
        state_valid <= 1'b0;
        while (pending_derivs.size() != 0)
            @(negedge clk);
        repeat (PIPE_DEPTH + 5) @(negedge clk);
    endtask

    function automatic logic [31:0] rand_word();
        case ($urandom_range(5))
            0: return $urandom_range(255);                  // tiny, near singular
            1: return -$urandom_range(255);
            2: return $urandom() >>> $urandom_range(31);    // any magnitude
            3: return {$urandom_range(1) ? 16'hffff : 16'h0000, 16'($urandom())};
            default: return $urandom();
        endcase
    endfunction

    function automatic state_t rand_state();
        state_t st;
        st.pos_x = rand_word();
        st.pos_y = rand_word();
        st.pos_z = rand_word();
        st.vel_x = $urandom();
        st.vel_y = $urandom();
        st.vel_z = $urandom();
        // sometimes zero out axes so that single-axis and origin cases recur
        if ($urandom_range(9) == 0) st.pos_x = '0;
        if ($urandom_range(9) == 0) st.pos_y = '0;
        if ($urandom_range(9) == 0) st.pos_z = '0;
        return st;
    endfunction

    function automatic state_t make_state(input logic [31:0] px, input logic [31:0] py,
                                          input logic [31:0] pz, input logic [31:0] v);
        state_t st;
        st.pos_x = px;
        st.pos_y = py;
        st.pos_z = pz;
        st.vel_x = v;
        st.vel_y = ~v;
        st.vel_z = v ^ 32'h5a5a_a5a5;
        return st;
    endfunction

    // origin, unit radius on each axis, word extremes, tiny radius
    task automatic test_directed_cases();
        send_state(make_state(32'h0, 32'h0, 32'h0, 32'h0000_0000));
        send_state(make_state(32'h0001_0000, 32'h0, 32'h0, 32'hffff_ffff));
        send_state(make_state(32'h0, 32'hffff_0000, 32'h0, 32'h8000_0000));
        send_state(make_state(32'h0, 32'h0, 32'h0001_0000, 32'h7fff_ffff));
        send_state(make_state(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 32'h1234_5678));
        send_state(make_state(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'hdead_beef));
        send_state(make_state(32'h8000_0000, 32'h7fff_ffff, 32'h0, 32'h0f0f_0f0f));
        send_state(make_state(32'h0000_0001, 32'h0, 32'h0, 32'h0000_0001));
        send_state(make_state(32'hffff_ffff, 32'h0000_0001, 32'hffff_ffff, 32'h8000_0001));
        send_state(make_state(32'h0000_0100, 32'hffff_ff00, 32'h0000_0080, 32'h0));
        drain_pipe();
    endtask

    // register extremes: thrust at both ends saturates, mu at zero and at its top
    task automatic test_register_extremes();
        set_regs(32'h7fff_ffff, 32'h7fff_ffff, 32'h8000_0000, 32'h0001_0000);
        for (int i = 0; i < 8; i++)
            send_state(rand_state());
        send_state(make_state(32'h0000_0001, 32'h0000_0001, 32'hffff_ffff, 32'h0));
        send_state(make_state(32'h0, 32'h0, 32'h0, 32'h1));
        drain_pipe();
        set_regs(32'h0, 32'h8000_0000, 32'h7fff_ffff, 32'hffff_0000);
        for (int i = 0; i < 5; i++)
            send_state(rand_state());
        drain_pipe();
        // top bit of the mu write is not part of the register
        set_regs(32'hffff_ffff, 32'h0, 32'h0, 32'h0);
        send_state(make_state(32'h0001_0000, 32'h0, 32'h0, 32'h0));
        drain_pipe();
    endtask

    // bulk random beats across several register settings
    task automatic test_random_states(input int count);
        for (int k = 0; k < 5; k++)
        begin
            set_regs($urandom() >> $urandom_range(31), rand_word(), rand_word(),
                     rand_word());
            for (int i = 0; i < count / 5; i++)
                send_state(rand_state());
            drain_pipe();
        end
    endtask

    // receiver stalls long enough to fill the pipe; sender keeps offering
    task automatic test_backpressure();
        hold_off_cycles = 3 * PIPE_DEPTH;
        for (int i = 0; i < 150; i++)
            send_state(rand_state());
        drain_pipe();
    endtask

    // last stretch at full rate, no gaps on either side
    task automatic test_full_rate();
        idle_bursts_on = 1'b0;
        set_regs(32'h0001_0000, 32'h0, 32'h0, 32'h0);
        for (int i = 0; i < 374; i++)
            send_state(rand_state());
        drain_pipe();
    endtask

    // receiver side: random stall bursts, and a long hold-off on request
    initial
    begin
        deriv_ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_off_cycles > 0)
            begin
                deriv_ready <= 1'b0;
                repeat (hold_off_cycles) @(negedge clk);
                hold_off_cycles = 0;
            end
            if (idle_bursts_on && $urandom_range(5) == 0)
            begin
                deriv_ready <= 1'b0;
                repeat ($urandom_range(9, 1) - 1) @(negedge clk);
            end
            else
                deriv_ready <= 1'b1;
        end
    end

    // checker: compare each accepted beat with the oldest prediction
    always @(posedge clk)
    begin
        deriv_t want;
        if (rst_n && deriv_valid && deriv_ready)
        begin
            if (pending_derivs.size() == 0)
            begin
                $display("derivative beat with nothing pending");
                mismatch_count++;
            end
            else
            begin
                want = pending_derivs.pop_front();
                if (deriv.dpos_x !== want.dpos_x)
                    report_mismatch("dpos_x", deriv.dpos_x, want.dpos_x);
                if (deriv.dpos_y !== want.dpos_y)
                    report_mismatch("dpos_y", deriv.dpos_y, want.dpos_y);
                if (deriv.dpos_z !== want.dpos_z)
                    report_mismatch("dpos_z", deriv.dpos_z, want.dpos_z);
                if (deriv.dvel_x !== want.dvel_x)
                    report_mismatch("dvel_x", deriv.dvel_x, want.dvel_x);
                if (deriv.dvel_y !== want.dvel_y)
                    report_mismatch("dvel_y", deriv.dvel_y, want.dvel_y);
                if (deriv.dvel_z !== want.dvel_z)
                    report_mismatch("dvel_z", deriv.dvel_z, want.dvel_z);
                if (deriv.singular !== want.singular)
                    report_mismatch("singular", deriv.singular, want.singular);
                if (deriv.overflow !== want.overflow)
                    report_mismatch("overflow", deriv.overflow, want.overflow);
                singular_seen += want.singular;
                overflow_seen += want.overflow;
            end
            derivs_seen++;
        end
    end

    // watchdog: too long with no beat on either channel
    always @(posedge clk)
    begin
        if ((state_valid && state_ready) || (deriv_valid && deriv_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("watchdog: no progress, %0d still pending", pending_derivs.size());
            $display("kepler_thrust_state_derivative_core_test: done, errors");
            $finish;
        end
    end

    initial
    begin
        rst_n            = 1'b0;
        state_valid      = 1'b0;
        state            = '0;
        cfg_we           = 1'b0;
        cfg_addr         = REG_GRAV_PARAM;
        cfg_data         = '0;
        mismatch_count   = 0;
        states_sent      = 0;
        derivs_seen      = 0;
        singular_seen    = 0;
        overflow_seen    = 0;
        quiet_cycles     = 0;
        hold_off_cycles  = 0;
        idle_bursts_on   = 1'b1;
        mu_shadow        = 31'h0001_0000;
        thrust_shadow[0] = '0;
        thrust_shadow[1] = '0;
        thrust_shadow[2] = '0;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_directed_cases();
        test_register_extremes();
        test_random_states(1000);
        test_backpressure();
        test_full_rate();

        $display("covered %0d state beats, %0d derivatives: %0d singular, %0d saturated",
                 states_sent, derivs_seen, singular_seen, overflow_seen);
        if (mismatch_count == 0)
            $display("kepler_thrust_state_derivative_core_test: done, clean");
        else
            $display("kepler_thrust_state_derivative_core_test: done, errors");
        $finish;
    end

endmodule
